// ----- design/assert_macros.svh -----
// Assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RTI_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RTI_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RTI_ASSERT_IMP(label, clk, rstn, ante, cons)
`define RTI_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

// ----- design/rti_pkg.sv -----
package rti_pkg;

    localparam int CW     = 20;
    localparam int DW     = CW + 1;
    localparam int PW     = 2 * DW;
    localparam int MW     = PW + 1;
    localparam int ML     = (MW + 1) / 2;
    localparam int PLW    = DW + ML + 1;
    localparam int PHW    = DW + MW - ML;
    localparam int TW     = DW + MW;
    localparam int DETW   = TW + 2;
    localparam int QW     = 32;
    localparam int QFRAC  = 16;
    localparam int BW     = QFRAC + 1;
    localparam int PRW    = QW + CW;
    localparam int HQW    = PRW - QFRAC;
    localparam int NTERM  = 12;
    localparam int NMINOR = 6;
    localparam int NPRE   = 9;
    localparam int NPOST  = 4;
    localparam int NST    = NPRE + QW + NPOST;

    localparam logic [BW-1:0] BARY_ONE = BW'(1) << QFRAC;
    localparam logic signed [QW-1:0] T_MAX = {1'b0, {(QW-1){1'b1}}};
    localparam logic signed [QW-1:0] T_MIN = {1'b1, {(QW-1){1'b0}}};
    localparam logic signed [HQW:0] HP_MAX = (HQW+1)'({1'b0, {(CW-1){1'b1}}});
    localparam logic signed [HQW:0] HP_MIN = -HP_MAX - (HQW+1)'(1);

    typedef enum logic [1:0] {
        REG_VERT_X = 2'd0,
        REG_VERT_Y = 2'd1,
        REG_VERT_Z = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        REASON_HIT       = 3'd0,
        REASON_BETA_OUT  = 3'd1,
        REASON_GAMMA_OUT = 3'd2,
        REASON_SUM_OVER  = 3'd3,
        REASON_BEHIND    = 3'd4,
        REASON_DEGEN     = 3'd5
    } miss_reason_t;

    typedef struct packed {
        logic [2:0][CW-1:0] org;
        logic [2:0][CW-1:0] dir;
    } ray_t;

    typedef struct packed {
        ray_t         ray;
        miss_reason_t reason;
        logic         degen;
        logic [2:0]   neg;
        logic [2:0]   ovf;
    } div_side_t;

    // row-0 operand: 0 ea, 1 eb, 2 ed, 3 dir; minors: 0 m 1 n 2 p 3 q 4 r 5 s
    localparam int unsigned TERM_ROW   [NTERM] = '{0, 1, 3, 2, 1, 3, 0, 2, 3, 0, 1, 2};
    localparam int unsigned TERM_MINOR [NTERM] = '{0, 3, 5, 0, 1, 2, 1, 3, 4, 2, 4, 5};
    localparam logic        TERM_NEG   [NTERM] = '{0, 0, 0, 0, 1, 1, 0, 0, 0, 0, 1, 0};

    function automatic logic signed [CW-1:0] vfield(input logic [3*CW-1:0] r, input int k);
        return $signed(r[k*CW +: CW]);
    endfunction

endpackage

// ----- design/ray_triangle_intersect_unit.sv -----
// Ray/triangle intersection, Cramer's rule, fully pipelined.
// Pipeline: 45 register stages from request accept to result valid (9 setup,
// 32 restoring-divider, 4 output). Throughput: one ray per cycle when not stalled.
// The whole pipeline advances when the output register is empty or taken.
// Reset: rst_n clears valid bits and vertex registers to zero.
`include "assert_macros.svh"

module ray_triangle_intersect_unit
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [3*rti_pkg::CW-1:0] cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [rti_pkg::CW-1:0] origin_x,
    input  logic signed [rti_pkg::CW-1:0] origin_y,
    input  logic signed [rti_pkg::CW-1:0] origin_z,
    input  logic signed [rti_pkg::CW-1:0] dir_x,
    input  logic signed [rti_pkg::CW-1:0] dir_y,
    input  logic signed [rti_pkg::CW-1:0] dir_z,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     hit,
    output logic [2:0]               miss_reason,
    output logic signed [rti_pkg::QW-1:0] distance,
    output logic [rti_pkg::BW-1:0]   bary_beta,
    output logic [rti_pkg::BW-1:0]   bary_gamma,
    output logic signed [rti_pkg::CW-1:0] hit_x,
    output logic signed [rti_pkg::CW-1:0] hit_y,
    output logic signed [rti_pkg::CW-1:0] hit_z
);

    localparam int CW   = rti_pkg::CW;
    localparam int DW   = rti_pkg::DW;
    localparam int PW   = rti_pkg::PW;
    localparam int MW   = rti_pkg::MW;
    localparam int ML   = rti_pkg::ML;
    localparam int PLW  = rti_pkg::PLW;
    localparam int PHW  = rti_pkg::PHW;
    localparam int TW   = rti_pkg::TW;
    localparam int DETW = rti_pkg::DETW;
    localparam int QW   = rti_pkg::QW;
    localparam int QF   = rti_pkg::QFRAC;
    localparam int BW   = rti_pkg::BW;
    localparam int PRW  = rti_pkg::PRW;
    localparam int HQW  = rti_pkg::HQW;
    localparam int NST  = rti_pkg::NST;

    logic                en;
    logic [NST-1:0]      vld_reg;
    logic [NST-1:0]      vld_next;
    logic [3*CW-1:0]     vert_reg [3];

    assign en       = !vld_reg[NST-1] || out_ready;
    assign in_ready = en;
    assign vld_next = {vld_reg[NST-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                vert_reg[i] <= '0;
            end
        end
        else
        begin
            if (en)
            begin
                vld_reg <= vld_next;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    rti_pkg::REG_VERT_X: vert_reg[0] <= cfg_data;
                    rti_pkg::REG_VERT_Y: vert_reg[1] <= cfg_data;
                    rti_pkg::REG_VERT_Z: vert_reg[2] <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // stage 1: edge vectors
    rti_pkg::ray_t       ray_in;
    logic signed [DW-1:0] ea_next [3], eb_next [3], ed_next [3];
    logic signed [DW-1:0] ea_reg [3], eb_reg [3], ed_reg [3];
    rti_pkg::ray_t       ray_reg [8];

    always_comb
    begin
        ray_in.org = {origin_z, origin_y, origin_x};
        ray_in.dir = {dir_z, dir_y, dir_x};
        for (int a = 0; a < 3; a++)
        begin
            ea_next[a] = DW'(rti_pkg::vfield(vert_reg[a], 0))
                       - DW'(rti_pkg::vfield(vert_reg[a], 1));
            eb_next[a] = DW'(rti_pkg::vfield(vert_reg[a], 0))
                       - DW'(rti_pkg::vfield(vert_reg[a], 2));
            ed_next[a] = DW'(rti_pkg::vfield(vert_reg[a], 0))
                       - DW'($signed(ray_in.org[a]));
        end
    end

    // stage 2: minor products
    logic signed [DW-1:0] dir_e [3];
    logic signed [DW-1:0] ma [12], mb [12];
    logic signed [PW-1:0] pr_reg [12];
    logic signed [DW-1:0] row0_s2_reg [4], row0_s3_reg [4];

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            dir_e[a] = DW'($signed(ray_reg[0].dir[a]));
        end
        ma[0]  = eb_reg[1]; mb[0]  = dir_e[2];  ma[1]  = dir_e[1];  mb[1]  = eb_reg[2];
        ma[2]  = ed_reg[1]; mb[2]  = dir_e[2];  ma[3]  = dir_e[1];  mb[3]  = ed_reg[2];
        ma[4]  = eb_reg[1]; mb[4]  = ed_reg[2]; ma[5]  = ed_reg[1]; mb[5]  = eb_reg[2];
        ma[6]  = dir_e[1];  mb[6]  = ea_reg[2]; ma[7]  = ea_reg[1]; mb[7]  = dir_e[2];
        ma[8]  = ea_reg[1]; mb[8]  = ed_reg[2]; ma[9]  = ed_reg[1]; mb[9]  = ea_reg[2];
        ma[10] = ea_reg[1]; mb[10] = eb_reg[2]; ma[11] = eb_reg[1]; mb[11] = ea_reg[2];
    end

    // stages 3..9
    logic signed [MW-1:0]   mn_reg [6];
    logic signed [PLW-1:0]  pl_reg [12];
    logic signed [PHW-1:0]  ph_reg [12];
    logic signed [TW-1:0]   tm_reg [12];
    logic signed [DETW-1:0] det_reg [4];
    logic signed [DETW-1:0] nrm_reg [4];
    logic                   degen7_reg, degen8_reg;
    logic [DETW-1:0]        mag_reg [3];
    logic [DETW-1:0]        dv8_reg;
    logic [2:0]             neg8_reg;
    rti_pkg::miss_reason_t  reason8_reg;
    logic signed [DW-1:0]   row0_s4 [4];
    logic signed [DETW:0]   sum12;
    rti_pkg::miss_reason_t  reason_c;

    assign row0_s4[0] = row0_s3_reg[0];
    assign row0_s4[1] = row0_s3_reg[1];
    assign row0_s4[2] = row0_s3_reg[2];
    assign row0_s4[3] = row0_s3_reg[3];

    always_comb
    begin
        sum12 = (DETW+1)'(nrm_reg[1]) + (DETW+1)'(nrm_reg[2]);
        if (nrm_reg[1] < 0 || nrm_reg[1] > nrm_reg[0])
        begin
            reason_c = rti_pkg::REASON_BETA_OUT;
        end
        else if (nrm_reg[2] < 0 || nrm_reg[2] > nrm_reg[0])
        begin
            reason_c = rti_pkg::REASON_GAMMA_OUT;
        end
        else if (sum12 > (DETW+1)'(nrm_reg[0]))
        begin
            reason_c = rti_pkg::REASON_SUM_OVER;
        end
        else if (nrm_reg[3] < 0)
        begin
            reason_c = rti_pkg::REASON_BEHIND;
        end
        else
        begin
            reason_c = rti_pkg::REASON_HIT;
        end
    end

    // divider pipeline, index 0 loaded by stage 9
    logic [DETW-1:0]     rem_reg [3][QW+1];
    logic [QW-1:0]       x_reg   [3][QW+1];
    logic [DETW-1:0]     d_reg   [QW+1];
    rti_pkg::div_side_t  side_reg [QW+1];
    logic [DETW:0]       trial   [3][QW];
    logic                ge      [3][QW];

    always_comb
    begin
        for (int k = 0; k < QW; k++)
        begin
            for (int l = 0; l < 3; l++)
            begin
                trial[l][k] = {rem_reg[l][k], x_reg[l][k][QW-1]};
                ge[l][k]    = trial[l][k] >= {1'b0, d_reg[k]};
            end
        end
    end

    // post stages
    logic [QW-1:0]            qt [3];
    logic signed [QW-1:0]     t_next;
    logic [BW-1:0]            bary_next [2];
    logic signed [QW-1:0]     t_reg [3];
    logic [BW-1:0]            beta_reg [3], gamma_reg [3];
    rti_pkg::div_side_t       ps_reg [3];
    logic signed [PRW-1:0]    prod_reg [3];
    logic signed [PRW-1:0]    prod_b [3];
    logic signed [HQW-1:0]    hq_reg [3];
    logic signed [HQW:0]      hp_sum [3];
    logic signed [CW-1:0]     hp_next [3];
    logic signed [QW-1:0]     dist_reg;
    logic [BW-1:0]            beta_o_reg, gamma_o_reg;
    logic [2:0]               reason_o_reg;
    logic signed [CW-1:0]     hp_reg [3];

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            qt[l] = x_reg[l][QW];
        end
        for (int l = 0; l < 2; l++)
        begin
            if (side_reg[QW].neg[l])
            begin
                bary_next[l] = '0;
            end
            else if (side_reg[QW].ovf[l] || qt[l][QW-1:QF] != '0)
            begin
                bary_next[l] = rti_pkg::BARY_ONE;
            end
            else
            begin
                bary_next[l] = BW'(qt[l][QF-1:0]);
            end
        end
        if (side_reg[QW].ovf[2] || qt[2][QW-1])
        begin
            t_next = side_reg[QW].neg[2] ? rti_pkg::T_MIN : rti_pkg::T_MAX;
        end
        else
        begin
            t_next = side_reg[QW].neg[2] ? -$signed(qt[2]) : $signed(qt[2]);
        end
        if (side_reg[QW].degen)
        begin
            t_next       = '0;
            bary_next[0] = '0;
            bary_next[1] = '0;
        end
        for (int a = 0; a < 3; a++)
        begin
            prod_b[a] = prod_reg[a] + (prod_reg[a] < 0 ? PRW'((1 << QF) - 1) : PRW'(0));
            hp_sum[a] = (HQW+1)'($signed(ps_reg[2].ray.org[a])) + (HQW+1)'(hq_reg[a]);
            if (ps_reg[2].degen)
            begin
                hp_next[a] = '0;
            end
            else if (hp_sum[a] > rti_pkg::HP_MAX)
            begin
                hp_next[a] = CW'(rti_pkg::HP_MAX);
            end
            else if (hp_sum[a] < rti_pkg::HP_MIN)
            begin
                hp_next[a] = CW'(rti_pkg::HP_MIN);
            end
            else
            begin
                hp_next[a] = CW'(hp_sum[a]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1
            for (int a = 0; a < 3; a++)
            begin
                ea_reg[a] <= ea_next[a];
                eb_reg[a] <= eb_next[a];
                ed_reg[a] <= ed_next[a];
            end
            ray_reg[0] <= ray_in;
            for (int s = 1; s < 8; s++)
            begin
                ray_reg[s] <= ray_reg[s-1];
            end
            // stage 2
            for (int j = 0; j < 12; j++)
            begin
                pr_reg[j] <= PW'(ma[j]) * PW'(mb[j]);
            end
            row0_s2_reg[0] <= ea_reg[0];
            row0_s2_reg[1] <= eb_reg[0];
            row0_s2_reg[2] <= ed_reg[0];
            row0_s2_reg[3] <= dir_e[0];
            // stage 3
            for (int k = 0; k < rti_pkg::NMINOR; k++)
            begin
                mn_reg[k] <= MW'(pr_reg[2*k]) - MW'(pr_reg[2*k+1]);
            end
            row0_s3_reg <= row0_s2_reg;
            // stage 4: split products
            for (int j = 0; j < rti_pkg::NTERM; j++)
            begin
                pl_reg[j] <= PLW'(row0_s4[rti_pkg::TERM_ROW[j]])
                           * PLW'($signed({1'b0, mn_reg[rti_pkg::TERM_MINOR[j]][ML-1:0]}));
                ph_reg[j] <= PHW'(row0_s4[rti_pkg::TERM_ROW[j]])
                           * PHW'($signed(mn_reg[rti_pkg::TERM_MINOR[j]][MW-1:ML]));
            end
            // stage 5
            for (int j = 0; j < rti_pkg::NTERM; j++)
            begin
                tm_reg[j] <= (TW'(ph_reg[j]) <<< ML) + TW'(pl_reg[j]);
            end
            // stage 6
            for (int i = 0; i < 4; i++)
            begin
                det_reg[i] <= (rti_pkg::TERM_NEG[3*i]   ? -DETW'(tm_reg[3*i])
                                                        :  DETW'(tm_reg[3*i]))
                            + (rti_pkg::TERM_NEG[3*i+1] ? -DETW'(tm_reg[3*i+1])
                                                        :  DETW'(tm_reg[3*i+1]))
                            + (rti_pkg::TERM_NEG[3*i+2] ? -DETW'(tm_reg[3*i+2])
                                                        :  DETW'(tm_reg[3*i+2]));
            end
            // stage 7: make denominator positive
            degen7_reg <= det_reg[0] == '0;
            for (int i = 0; i < 4; i++)
            begin
                nrm_reg[i] <= det_reg[0][DETW-1] ? -det_reg[i] : det_reg[i];
            end
            // stage 8
            reason8_reg <= reason_c;
            degen8_reg  <= degen7_reg;
            dv8_reg     <= nrm_reg[0];
            for (int l = 0; l < 3; l++)
            begin
                neg8_reg[l] <= nrm_reg[l+1][DETW-1];
                mag_reg[l]  <= nrm_reg[l+1][DETW-1] ? DETW'(-nrm_reg[l+1]) : nrm_reg[l+1];
            end
            // stage 9: divider load
            for (int l = 0; l < 3; l++)
            begin
                side_reg[0].ovf[l] <= (DETW+QF)'(mag_reg[l]) >= ((DETW+QF)'(dv8_reg) << QF);
                rem_reg[l][0]      <= mag_reg[l] >> QF;
                x_reg[l][0]        <= {mag_reg[l][QF-1:0], {(QW-QF){1'b0}}};
            end
            side_reg[0].ray    <= ray_reg[7];
            side_reg[0].reason <= degen8_reg ? rti_pkg::REASON_DEGEN : reason8_reg;
            side_reg[0].degen  <= degen8_reg;
            side_reg[0].neg    <= neg8_reg;
            d_reg[0]           <= dv8_reg;
            // divider steps
            for (int k = 0; k < QW; k++)
            begin
                for (int l = 0; l < 3; l++)
                begin
                    rem_reg[l][k+1] <= ge[l][k] ? DETW'(trial[l][k] - {1'b0, d_reg[k]})
                                                : DETW'(trial[l][k]);
                    x_reg[l][k+1]   <= {x_reg[l][k][QW-2:0], ge[l][k]};
                end
                d_reg[k+1]    <= d_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
            // post 1
            t_reg[0]     <= t_next;
            beta_reg[0]  <= bary_next[0];
            gamma_reg[0] <= bary_next[1];
            ps_reg[0]    <= side_reg[QW];
            // post 2
            for (int a = 0; a < 3; a++)
            begin
                prod_reg[a] <= PRW'(t_reg[0]) * PRW'($signed(ps_reg[0].ray.dir[a]));
            end
            // post 3
            for (int a = 0; a < 3; a++)
            begin
                hq_reg[a] <= HQW'(prod_b[a] >>> QF);
            end
            for (int s = 1; s < 3; s++)
            begin
                t_reg[s]     <= t_reg[s-1];
                beta_reg[s]  <= beta_reg[s-1];
                gamma_reg[s] <= gamma_reg[s-1];
                ps_reg[s]    <= ps_reg[s-1];
            end
            // post 4: output register
            dist_reg     <= t_reg[2];
            beta_o_reg   <= beta_reg[2];
            gamma_o_reg  <= gamma_reg[2];
            reason_o_reg <= ps_reg[2].reason;
            for (int a = 0; a < 3; a++)
            begin
                hp_reg[a] <= hp_next[a];
            end
        end
    end

    assign out_valid   = vld_reg[NST-1];
    assign hit         = reason_o_reg == rti_pkg::REASON_HIT;
    assign miss_reason = reason_o_reg;
    assign distance    = dist_reg;
    assign bary_beta   = beta_o_reg;
    assign bary_gamma  = gamma_o_reg;
    assign hit_x       = hp_reg[0];
    assign hit_y       = hp_reg[1];
    assign hit_z       = hp_reg[2];

    logic [BW:0] bary_sum;
    logic        degen_out;
    logic        degen_clear;

    assign bary_sum    = (BW+1)'(bary_beta) + (BW+1)'(bary_gamma);
    assign degen_out   = out_valid && miss_reason == rti_pkg::REASON_DEGEN;
    assign degen_clear = distance == 0 && bary_beta == 0 && hit_x == 0;

    `RTI_ASSERT_IMP(a_hit_dist, clk, rst_n, out_valid && hit, distance >= 0)
    `RTI_ASSERT_IMP(a_hit_bary, clk, rst_n, out_valid && hit, bary_sum <= (BW+1)'(rti_pkg::BARY_ONE))
    `RTI_ASSERT_IMP(a_degen_zero, clk, rst_n, degen_out, degen_clear)
    `RTI_ASSERT_NXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(distance))

endmodule

// ----- verif/ray_triangle_intersect_unit_test.sv -----
module ray_triangle_intersect_unit_test;

    localparam int CW = rti_pkg::CW;
    localparam int QW = rti_pkg::QW;
    localparam int BW = rti_pkg::BW;
    localparam int CLK_HALF = 4;
    localparam int DRAIN_CYCLES = 60;
    localparam int PHASES = 8;
    localparam int RAYS_PER_PHASE = 168;
    localparam logic [1:0] CFG_IDX_SPARE = 2'd3;
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
    localparam int ONE = 1024;
    localparam int PLANE_Z = 5 * ONE;

    typedef enum int { IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH } idle_mode_t;

    typedef struct {
        logic signed [CW-1:0] org [3];
        logic signed [CW-1:0] dir [3];
    } ray_s;

    typedef struct {
        logic                  hit;
        rti_pkg::miss_reason_t reason;
        logic signed [QW-1:0]  t_dist;
        logic [BW-1:0]         beta;
        logic [BW-1:0]         gamma;
        logic signed [CW-1:0]  pt [3];
    } isect_t;

    typedef struct {
        ray_s ray;
        logic degen_expected;
    } plan_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [1:0]           cfg_index;
    logic [3*CW-1:0]      cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic signed [CW-1:0] origin_x, origin_y, origin_z;
    logic signed [CW-1:0] dir_x, dir_y, dir_z;
    logic                 out_valid;
    logic                 out_ready;
    logic                 hit;
    logic [2:0]           miss_reason;
    logic signed [QW-1:0] distance;
    logic [BW-1:0]        bary_beta;
    logic [BW-1:0]        bary_gamma;
    logic signed [CW-1:0] hit_x, hit_y, hit_z;

    logic [3*CW-1:0] vert_regs [3];
    isect_t          pending_hits [$];
    idle_mode_t      idle_mode;
    int              errors;
    int              rays_sent;
    int              results_seen;
    int              reason_count [6];
    plan_row_t       plan [$];

    ray_triangle_intersect_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .origin_x   (origin_x),
        .origin_y   (origin_y),
        .origin_z   (origin_z),
        .dir_x      (dir_x),
        .dir_y      (dir_y),
        .dir_z      (dir_z),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hit        (hit),
        .miss_reason(miss_reason),
        .distance   (distance),
        .bary_beta  (bary_beta),
        .bary_gamma (bary_gamma),
        .hit_x      (hit_x),
        .hit_y      (hit_y),
        .hit_z      (hit_z)
    );

    always
    begin
        clk = 1'b1;
        #CLK_HALF;
        clk = 1'b0;
        #CLK_HALF;
    end

    function automatic isect_t degenerate_result();
        isect_t res;
        res.hit = 1'b0;
        res.reason = rti_pkg::REASON_DEGEN;
        res.t_dist = '0;
        res.beta = '0;
        res.gamma = '0;
        for (int ax = 0; ax < 3; ax++)
        begin
            res.pt[ax] = '0;
        end
        return res;
    endfunction

    function automatic isect_t trace_ray(ray_s r);
        logic signed [127:0] vx [3];
        logic signed [127:0] o [3];
        logic signed [127:0] c [3];
        logic signed [127:0] ea [3];
        logic signed [127:0] eb [3];
        logic signed [127:0] ed [3];
        logic signed [127:0] m, n, p, q, rr, s, den, e1, e2, e3, quo, hp;
        logic signed [63:0]  tv;
        isect_t              res;
        for (int ax = 0; ax < 3; ax++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                vx[k] = $signed(vert_regs[ax][k*CW +: CW]);
            end
            o[ax] = r.org[ax];
            c[ax] = r.dir[ax];
            ea[ax] = vx[0] - vx[1];
            eb[ax] = vx[0] - vx[2];
            ed[ax] = vx[0] - o[ax];
        end
        m  = eb[1] * c[2] - c[1] * eb[2];
        n  = ed[1] * c[2] - c[1] * ed[2];
        p  = eb[1] * ed[2] - ed[1] * eb[2];
        q  = c[1] * ea[2] - ea[1] * c[2];
        rr = ea[1] * ed[2] - ed[1] * ea[2];
        s  = ea[1] * eb[2] - eb[1] * ea[2];
        den = ea[0] * m + eb[0] * q + c[0] * s;
        e1  = ed[0] * m - eb[0] * n - c[0] * p;
        e2  = ea[0] * n + ed[0] * q + c[0] * rr;
        e3  = ea[0] * p - eb[0] * rr + ed[0] * s;
        if (den == 0)
        begin
            return degenerate_result();
        end
        if (den < 0)
        begin
            den = -den;
            e1 = -e1;
            e2 = -e2;
            e3 = -e3;
        end
        if (e1 < 0 || e1 > den)
        begin
            res.reason = rti_pkg::REASON_BETA_OUT;
        end
        else if (e2 < 0 || e2 > den)
        begin
            res.reason = rti_pkg::REASON_GAMMA_OUT;
        end
        else if (e1 + e2 > den)
        begin
            res.reason = rti_pkg::REASON_SUM_OVER;
        end
        else if (e3 < 0)
        begin
            res.reason = rti_pkg::REASON_BEHIND;
        end
        else
        begin
            res.reason = rti_pkg::REASON_HIT;
        end
        res.hit = (res.reason == rti_pkg::REASON_HIT);
        quo = (e1 * 65536) / den;
        res.beta = (quo < 0) ? BW'(0) : (quo > 65536) ? BW'(65536) : BW'(quo);
        quo = (e2 * 65536) / den;
        res.gamma = (quo < 0) ? BW'(0) : (quo > 65536) ? BW'(65536) : BW'(quo);
        quo = (e3 * 65536) / den;
        if (quo > 128'sd2147483647)
        begin
            tv = 64'sd2147483647;
        end
        else if (quo < -128'sd2147483648)
        begin
            tv = -64'sd2147483648;
        end
        else
        begin
            tv = quo[63:0];
        end
        res.t_dist = tv[QW-1:0];
        for (int ax = 0; ax < 3; ax++)
        begin
            hp = o[ax] + (tv * c[ax]) / 65536;
            if (hp > CMAX)
            begin
                hp = CMAX;
            end
            if (hp < CMIN)
            begin
                hp = CMIN;
            end
            res.pt[ax] = hp[CW-1:0];
        end
        return res;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [3*CW-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx != CFG_IDX_SPARE)
        begin
            vert_regs[idx] = value;
        end
    endtask

    task automatic load_triangle(logic signed [CW-1:0] v [3][3]);
        write_reg(rti_pkg::REG_VERT_X, {v[2][0], v[1][0], v[0][0]});
        write_reg(rti_pkg::REG_VERT_Y, {v[2][1], v[1][1], v[0][1]});
        write_reg(rti_pkg::REG_VERT_Z, {v[2][2], v[1][2], v[0][2]});
    endtask

    task automatic wait_idle();
        while (pending_hits.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_ray(ray_s r, logic degen_expected);
        if (idle_mode == IDLE_SENDER || idle_mode == IDLE_BOTH)
        begin
            if ($urandom_range(99) < (idle_mode == IDLE_SENDER ? 74 : 28))
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while ($urandom_range(99) < (idle_mode == IDLE_SENDER ? 74 : 28))
                begin
                    @(posedge clk);
                end
            end
        end
        in_valid <= 1'b1;
        origin_x <= r.org[0];
        origin_y <= r.org[1];
        origin_z <= r.org[2];
        dir_x <= r.dir[0];
        dir_y <= r.dir[1];
        dir_z <= r.dir[2];
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        pending_hits.push_back(degen_expected ? degenerate_result() : trace_ray(r));
        rays_sent++;
    endtask

    function automatic ray_s make_ray(int ox, int oy, int oz, int dx, int dy, int dz);
        ray_s r;
        r.org[0] = CW'(ox);
        r.org[1] = CW'(oy);
        r.org[2] = CW'(oz);
        r.dir[0] = CW'(dx);
        r.dir[1] = CW'(dy);
        r.dir[2] = CW'(dz);
        return r;
    endfunction

    function automatic int spread(int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    function automatic logic signed [CW-1:0] any_coord();
        return CW'($urandom());
    endfunction

    function automatic ray_s aimed_ray(logic signed [CW-1:0] v [3][3]);
        ray_s r;
        int   b, g, tgt, og;
        logic backward;
        b = spread(1280) + 512;
        g = spread(1280) + 512;
        backward = ($urandom_range(9) == 0);
        for (int ax = 0; ax < 3; ax++)
        begin
            tgt = v[0][ax] + (b * (v[1][ax] - v[0][ax])) / ONE
                + (g * (v[2][ax] - v[0][ax])) / ONE;
            og = tgt + spread(16 * ONE);
            r.org[ax] = CW'(og);
            r.dir[ax] = CW'(backward ? og - tgt : tgt - og);
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        isect_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (pending_hits.size() == 0)
                begin
                    $error("result with no request outstanding");
                    errors++;
                end
                else
                begin
                    want = pending_hits.pop_front();
                    reason_count[want.reason]++;
                    if (hit !== want.hit)
                    begin
                        $error("hit: expected %0d, got %0d", want.hit, hit);
                        errors++;
                    end
                    if (miss_reason !== want.reason)
                    begin
                        $error("miss_reason: expected %0d, got %0d", want.reason, miss_reason);
                        errors++;
                    end
                    if (distance !== want.t_dist)
                    begin
                        $error("distance: expected %0d, got %0d", want.t_dist, distance);
                        errors++;
                    end
                    if (bary_beta !== want.beta)
                    begin
                        $error("bary_beta: expected %0d, got %0d", want.beta, bary_beta);
                        errors++;
                    end
                    if (bary_gamma !== want.gamma)
                    begin
                        $error("bary_gamma: expected %0d, got %0d", want.gamma, bary_gamma);
                        errors++;
                    end
                    if (hit_x !== want.pt[0])
                    begin
                        $error("hit_x: expected %0d, got %0d", want.pt[0], hit_x);
                        errors++;
                    end
                    if (hit_y !== want.pt[1])
                    begin
                        $error("hit_y: expected %0d, got %0d", want.pt[1], hit_y);
                        errors++;
                    end
                    if (hit_z !== want.pt[2])
                    begin
                        $error("hit_z: expected %0d, got %0d", want.pt[2], hit_z);
                        errors++;
                    end
                end
            end
            if (idle_mode == IDLE_RECEIVER)
            begin
                out_ready <= ($urandom_range(99) >= 74);
            end
            else if (idle_mode == IDLE_BOTH)
            begin
                out_ready <= ($urandom_range(99) >= 28);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        #20000000;
        $display("ray_triangle_intersect_unit_test: FAIL");
        $finish;
    end

    initial
    begin
        logic signed [CW-1:0] tri_v [3][3];
        ray_s r;
        errors = 0;
        rays_sent = 0;
        results_seen = 0;
        for (int k = 0; k < 6; k++)
        begin
            reason_count[k] = 0;
        end
        for (int ax = 0; ax < 3; ax++)
        begin
            vert_regs[ax] = '0;
        end
        idle_mode = IDLE_NONE;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        origin_x = '0;
        origin_y = '0;
        origin_z = '0;
        dir_x = '0;
        dir_y = '0;
        dir_z = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all vertices at zero after reset: every ray is degenerate
        send_ray(make_ray(CMAX, CMIN, 12345, CMAX, CMIN, 777), 1'b1);
        in_valid <= 1'b0;
        wait_idle();

        tri_v[0][0] = '0;          tri_v[0][1] = '0;          tri_v[0][2] = CW'(PLANE_Z);
        tri_v[1][0] = CW'(ONE);    tri_v[1][1] = '0;          tri_v[1][2] = CW'(PLANE_Z);
        tri_v[2][0] = '0;          tri_v[2][1] = CW'(ONE);    tri_v[2][2] = CW'(PLANE_Z);
        load_triangle(tri_v);
        write_reg(CFG_IDX_SPARE, {(3*CW){1'b1}});

        plan.push_back('{make_ray(256, 256, 0, 0, 0, ONE), 1'b0});
        plan.push_back('{make_ray(-512, 256, 0, 0, 0, ONE), 1'b0});
        plan.push_back('{make_ray(256, 2048, 0, 0, 0, ONE), 1'b0});
        plan.push_back('{make_ray(700, 700, 0, 0, 0, ONE), 1'b0});
        plan.push_back('{make_ray(256, 256, 0, 0, 0, -ONE), 1'b0});
        plan.push_back('{make_ray(256, 256, 0, 0, 0, 0), 1'b1});
        plan.push_back('{make_ray(0, 0, 0, ONE, 0, 0), 1'b1});
        plan.push_back('{make_ray(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX), 1'b0});
        plan.push_back('{make_ray(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN), 1'b0});
        plan.push_back('{make_ray(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX), 1'b0});
        plan.push_back('{make_ray(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN), 1'b0});
        plan.push_back('{make_ray(0, 0, 0, 0, 0, ONE), 1'b0});
        plan.push_back('{make_ray(ONE, 0, 0, 0, 0, ONE), 1'b0});
        plan.push_back('{make_ray(0, ONE, 0, 0, 0, ONE), 1'b0});
        plan.push_back('{make_ray(512, 512, 0, 0, 0, ONE), 1'b0});
        plan.push_back('{make_ray(300, 200, PLANE_Z, 0, 0, ONE), 1'b0});
        plan.push_back('{make_ray(256, 256, CMIN, 0, 0, 1), 1'b0});
        plan.push_back('{make_ray(256, 256, 0, 0, 0, 1), 1'b0});
        plan.push_back('{make_ray(256, 256, 0, CMAX, CMIN, 1), 1'b0});
        plan.push_back('{make_ray(200, 100, 9 * ONE, 50, -30, -ONE), 1'b0});
        foreach (plan[i])
        begin
            send_ray(plan[i].ray, plan[i].degen_expected);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            in_valid <= 1'b0;
            wait_idle();
            idle_mode = idle_mode_t'(ph % 4);
            for (int k = 0; k < 3; k++)
            begin
                for (int ax = 0; ax < 3; ax++)
                begin
                    if (ph == 3)
                    begin
                        tri_v[k][ax] = (k == 0) ? CMAX : (k == 1) ? CMIN : '0;
                    end
                    else if (ph == 6)
                    begin
                        tri_v[k][ax] = any_coord();
                    end
                    else
                    begin
                        tri_v[k][ax] = CW'(spread(4 * ONE));
                    end
                end
            end
            load_triangle(tri_v);
            for (int i = 0; i < RAYS_PER_PHASE; i++)
            begin
                if (ph == 3 || ph == 6 || $urandom_range(3) == 0)
                begin
                    r = make_ray(any_coord(), any_coord(), any_coord(),
                                 any_coord(), any_coord(), any_coord());
                end
                else
                begin
                    r = aimed_ray(tri_v);
                end
                send_ray(r, 1'b0);
            end
        end
        in_valid <= 1'b0;
        wait_idle();

        $display("covered %0d rays (%0d results checked) over %0d vertex settings, four idle patterns",
                 rays_sent, results_seen, PHASES + 2);
        $display("results: hit %0d, beta %0d, gamma %0d, sum %0d, behind %0d, degenerate %0d",
                 reason_count[0], reason_count[1], reason_count[2],
                 reason_count[3], reason_count[4], reason_count[5]);
        if (errors == 0 && pending_hits.size() == 0)
        begin
            $display("ray_triangle_intersect_unit_test: PASS");
        end
        else
        begin
            $display("ray_triangle_intersect_unit_test: FAIL");
        end
        $finish;
    end

endmodule
